// ===== design/gtp_pkg.sv =====
// ============================================================================
// GUID text parser package
// Shared types and constants for the GUID text parser blocks.
// ============================================================================
`default_nettype none

package gtp_pkg;

    localparam int CHAR_BITS = 16;
    localparam int CODE_W    = 16;

    localparam logic [CODE_W-1:0] CHAR_MASK =
        CODE_W'((32'd1 << CHAR_BITS) - 32'd1);

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              start;
    } char_item_t;

    typedef struct packed {
        logic        emit;
        logic        ok;
        logic [31:0] first_word;
        logic [15:0] second_half;
        logic [15:0] third_half;
        logic [63:0] tail_bytes;
    } result_t;

endpackage

`default_nettype wire

// ===== design/gtp_char_stage.sv =====
// ============================================================================
// GUID text parser input register
// Captures one character transaction and holds it until the parser takes it.
// ============================================================================
`default_nettype none

module gtp_char_stage
    import gtp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CODE_W-1:0] char_code,
    input  wire logic              start_req,
    input  wire logic              advance,
    output logic                   item_valid,
    output char_item_t             item
);

    logic       valid_reg;
    logic       valid_next;
    char_item_t item_reg;

    assign in_stall   = valid_reg && !advance;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.code  <= char_code;
            item_reg.start <= start_req;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

`ifndef SYNTH
    a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> valid_reg && $stable(item_reg))
        else $error("held character changed while stalled");
`endif

endmodule

`default_nettype wire

// ===== design/gtp_parser.sv =====
// ============================================================================
// GUID text parser core
// Holds the parse state and works out one character per step.
// ============================================================================
`default_nettype none

module gtp_parser
    import gtp_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       step,
    input  wire char_item_t item,
    output result_t         res
);

    typedef enum logic [10:0] {
        PH_IDLE       = 11'b000_0000_0001,
        PH_LEAD       = 11'b000_0000_0010,
        PH_GRP1       = 11'b000_0000_0100,
        PH_DASH1      = 11'b000_0000_1000,
        PH_GRP2       = 11'b000_0001_0000,
        PH_DASH2      = 11'b000_0010_0000,
        PH_GRP3       = 11'b000_0100_0000,
        PH_DASH3      = 11'b000_1000_0000,
        PH_PAIR_OPEN  = 11'b001_0000_0000,
        PH_PAIR_DIGIT = 11'b010_0000_0000,
        PH_DONE       = 11'b100_0000_0000
    } phase_t;

    localparam logic [CODE_W-1:0] CH_DASH  = CODE_W'('h2D);
    localparam logic [CODE_W-1:0] CH_BRACE = CODE_W'('h7B);
    localparam logic [CODE_W-1:0] CH_NUL   = '0;
    localparam logic [CODE_W-1:0] CH_SPACE = CODE_W'('h20);
    localparam logic [CODE_W-1:0] CH_TAB   = CODE_W'('h09);
    localparam logic [CODE_W-1:0] CH_CR    = CODE_W'('h0D);

    function automatic logic [4:0] nibble_of(input logic [CODE_W-1:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= CODE_W'('h30) && c <= CODE_W'('h39))
        begin
            r = {1'b1, c[3:0]};
        end
        else if ((c >= CODE_W'('h61) && c <= CODE_W'('h66)) ||
                 (c >= CODE_W'('h41) && c <= CODE_W'('h46)))
        begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    phase_t      phase_reg, phase_next;
    logic [3:0]  dc_reg, dc_next;
    logic [3:0]  bi_reg, bi_next;
    logic [63:0] v0_reg, v0_next;
    logic [63:0] v1_reg, v1_next;

    logic [CODE_W-1:0] c;
    logic [4:0]        nib;
    logic              blank;
    logic              used;
    logic              emit;
    logic              good;
    logic [3:0]        need;

    assign c     = item.code & CHAR_MASK;
    assign nib   = nibble_of(c);
    assign blank = (c >= CH_TAB && c <= CH_CR) || c == CH_SPACE;

    always_comb
    begin
        phase_next = phase_reg;
        dc_next    = dc_reg;
        bi_next    = bi_reg;
        v0_next    = v0_reg;
        v1_next    = v1_reg;
        used       = 1'b0;
        emit       = 1'b0;
        good       = 1'b0;
        need       = 4'd4;

        if (item.start)
        begin
            phase_next = PH_LEAD;
            dc_next    = '0;
            bi_next    = '0;
            v0_next    = '0;
            v1_next    = '0;
        end

        if (phase_next == PH_LEAD)
        begin
            if (blank)
            begin
                used = 1'b1;
            end
            else if (c == CH_NUL)
            begin
                used = 1'b1;
                emit = 1'b1;
            end
            else
            begin
                phase_next = PH_GRP1;
                used       = (c == CH_BRACE);
            end
        end

        if (!used)
        begin
            case (phase_next)
                PH_GRP1, PH_GRP2, PH_GRP3:
                begin
                    used = 1'b1;
                    need = (phase_next == PH_GRP1) ? 4'd8 : 4'd4;
                    if (!nib[4])
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        v0_next = {v0_next[59:0], nib[3:0]};
                        dc_next = dc_next + 4'd1;
                        if (dc_next >= need)
                        begin
                            dc_next = '0;
                            case (phase_next)
                                PH_GRP1: phase_next = PH_DASH1;
                                PH_GRP2: phase_next = PH_DASH2;
                                default: phase_next = PH_DASH3;
                            endcase
                        end
                    end
                end
                PH_DASH1, PH_DASH2, PH_DASH3:
                begin
                    used = 1'b1;
                    if (c != CH_DASH)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        case (phase_next)
                            PH_DASH1: phase_next = PH_GRP2;
                            PH_DASH2: phase_next = PH_GRP3;
                            default:  phase_next = PH_PAIR_OPEN;
                        endcase
                    end
                end
                PH_PAIR_OPEN:
                begin
                    phase_next = PH_PAIR_DIGIT;
                    used       = (c == CH_DASH);
                end
                default:
                begin
                    used = 1'b0;
                end
            endcase
        end

        if (!used && phase_next == PH_PAIR_DIGIT)
        begin
            if (!nib[4])
            begin
                emit = 1'b1;
            end
            else
            begin
                v1_next = {v1_next[59:0], nib[3:0]};
                dc_next = dc_next + 4'd1;
                if (dc_next >= 4'd2)
                begin
                    dc_next = '0;
                    bi_next = bi_next + 4'd1;
                    if (bi_next >= 4'd8)
                    begin
                        emit = 1'b1;
                        good = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_PAIR_OPEN;
                    end
                end
            end
        end

        if (emit)
        begin
            phase_next = PH_DONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            dc_reg    <= '0;
            bi_reg    <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            dc_reg    <= dc_next;
            bi_reg    <= bi_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    always_comb
    begin
        res.emit        = step && emit;
        res.ok          = good;
        res.first_word  = good ? v0_next[63:32] : '0;
        res.second_half = good ? v0_next[31:16] : '0;
        res.third_half  = good ? v0_next[15:0]  : '0;
        res.tail_bytes  = good ? v1_next        : '0;
    end

`ifndef SYNTH
    a_result_ends_parse: assert property (@(posedge clk) disable iff (!rst_n)
        res.emit |=> phase_reg == PH_DONE)
        else $error("parse continued after its result");

    a_pair_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PAIR_OPEN || phase_reg == PH_PAIR_DIGIT) |-> bi_reg < 4'd8)
        else $error("byte index ran past the last pair");

    a_success_at_last_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (res.emit && res.ok) |-> (bi_reg == 4'd7 && phase_reg == PH_PAIR_DIGIT))
        else $error("success reported before the eighth byte");
`endif

endmodule

`default_nettype wire

// ===== design/gtp_result_stage.sv =====
// ============================================================================
// GUID text parser result register
// Holds one result transaction until the receiver takes it.
// ============================================================================
`default_nettype none

module gtp_result_stage
    import gtp_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire result_t res,
    output logic         advance,
    output logic         out_valid,
    input  wire logic    out_stall,
    output logic         ok,
    output logic [31:0]  first_word,
    output logic [15:0]  second_half,
    output logic [15:0]  third_half,
    output logic [63:0]  tail_bytes
);

    logic    valid_reg;
    logic    valid_next;
    result_t data_reg;

    assign advance    = !valid_reg || !out_stall;
    assign valid_next = advance ? res.emit : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
        begin
            data_reg <= res;
        end
    end

    assign out_valid   = valid_reg;
    assign ok          = data_reg.ok;
    assign first_word  = data_reg.first_word;
    assign second_half = data_reg.second_half;
    assign third_half  = data_reg.third_half;
    assign tail_bytes  = data_reg.tail_bytes;

`ifndef SYNTH
    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !data_reg.ok) |->
            (data_reg.first_word == '0 && data_reg.second_half == '0 &&
             data_reg.third_half == '0 && data_reg.tail_bytes == '0))
        else $error("failed parse carries a nonzero value");
`endif

endmodule

`default_nettype wire

// ===== design/guid_text_parser.sv =====
// ============================================================================
// GUID text parser
// Reads a textual GUID one character per transaction and returns its value.
// ============================================================================
// Each input transaction carries one character; start_req marks the first
// character of a string. The block takes one character every cycle while the
// output side keeps up. The character that ends the parse is first held in
// the input register; the parse logic then loads its result into the result
// register. A stall on the output holds the result register, which in turn
// stalls the input once the input register is also full. Each string gives
// at most one result, either the 128-bit value or a failure with all value
// fields zero.
// ============================================================================
`default_nettype none

module guid_text_parser
    import gtp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CODE_W-1:0] char_code,
    input  wire logic              start_req,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   ok,
    output logic [31:0]            first_word,
    output logic [15:0]            second_half,
    output logic [15:0]            third_half,
    output logic [63:0]            tail_bytes
);

    logic       advance;
    logic       item_valid;
    char_item_t item;
    result_t    res;

    gtp_char_stage u_char_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .char_code  (char_code),
        .start_req  (start_req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    gtp_parser u_parser (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (item_valid && advance),
        .item  (item),
        .res   (res)
    );

    gtp_result_stage u_result_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .res         (res),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .first_word  (first_word),
        .second_half (second_half),
        .third_half  (third_half),
        .tail_bytes  (tail_bytes)
    );

endmodule

`default_nettype wire

// ===== sim/guid_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// GUID text parser checker
// Watches both channels of the parser, predicts the result of every string
// from the accepted characters and compares each returned transaction with
// the oldest prediction.
// ============================================================================

module guid_checker
    import gtp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_stall,
    input  wire logic [CODE_W-1:0] char_code,
    input  wire logic              start_req,
    input  wire logic              out_valid,
    input  wire logic              out_stall,
    input  wire logic              ok,
    input  wire logic [31:0]       first_word,
    input  wire logic [15:0]       second_half,
    input  wire logic [15:0]       third_half,
    input  wire logic [63:0]       tail_bytes,
    output int                     fail_count,
    output int                     pending_guids
);

    localparam logic [CODE_W-1:0] CH_NUL    = 16'h0000;
    localparam logic [CODE_W-1:0] CH_SPACE  = 16'h0020;
    localparam logic [CODE_W-1:0] CH_DASH   = 16'h002D;
    localparam logic [CODE_W-1:0] CH_LBRACE = 16'h007B;

    typedef enum logic [3:0] {
        SCAN_IDLE,
        SCAN_BLANKS,
        SCAN_WORD,
        SCAN_SEP1,
        SCAN_HALF2,
        SCAN_SEP2,
        SCAN_HALF3,
        SCAN_SEP3,
        SCAN_BYTE_SEP,
        SCAN_BYTE_DIGIT,
        SCAN_FINISHED
    } scan_state_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] first_word;
        logic [15:0] second_half;
        logic [15:0] third_half;
        logic [63:0] tail_bytes;
    } guid_value_t;

    scan_state_t scan;
    logic [3:0]  digits;
    logic [3:0]  bytes_seen;
    logic [63:0] group_bits;
    logic [63:0] byte_bits;
    guid_value_t parsed_guids[$];
    int          fail_total;

    function automatic int hex_value(input logic [CODE_W-1:0] c);
        if (c >= 16'h30 && c <= 16'h39)
            return int'(c - 16'h30);
        if (c >= 16'h61 && c <= 16'h66)
            return int'(c - 16'h61) + 10;
        if (c >= 16'h41 && c <= 16'h46)
            return int'(c - 16'h41) + 10;
        return -1;
    endfunction

    task automatic emit_guid(input bit good);
        guid_value_t g;
        g.ok          = good;
        g.first_word  = good ? group_bits[63:32] : 32'd0;
        g.second_half = good ? group_bits[31:16] : 16'd0;
        g.third_half  = good ? group_bits[15:0]  : 16'd0;
        g.tail_bytes  = good ? byte_bits : 64'd0;
        parsed_guids.push_back(g);
        scan = SCAN_FINISHED;
    endtask

    task automatic parse_char(input logic [CODE_W-1:0] raw, input logic start);
        logic [CODE_W-1:0] c;
        int                nib;
        int                need;
        bit                used;
        c = raw & CHAR_MASK;
        used = 1'b0;
        if (start)
        begin
            scan       = SCAN_BLANKS;
            digits     = 4'd0;
            bytes_seen = 4'd0;
            group_bits = 64'd0;
            byte_bits  = 64'd0;
        end
        if (scan == SCAN_BLANKS)
        begin
            used = 1'b1;
            if ((c >= 16'd9 && c <= 16'd13) || c == CH_SPACE)
            begin
            end
            else if (c == CH_NUL)
                emit_guid(1'b0);
            else
            begin
                scan = SCAN_WORD;
                used = (c == CH_LBRACE);
            end
        end
        if (!used && (scan == SCAN_WORD || scan == SCAN_HALF2 || scan == SCAN_HALF3))
        begin
            used = 1'b1;
            need = (scan == SCAN_WORD) ? 8 : 4;
            nib = hex_value(c);
            if (nib < 0)
                emit_guid(1'b0);
            else
            begin
                group_bits = {group_bits[59:0], nib[3:0]};
                digits = digits + 4'd1;
                if (digits >= need)
                begin
                    digits = 4'd0;
                    scan = scan_state_t'(scan + 4'd1);
                end
            end
        end
        else if (!used && (scan == SCAN_SEP1 || scan == SCAN_SEP2 || scan == SCAN_SEP3))
        begin
            used = 1'b1;
            if (c != CH_DASH)
                emit_guid(1'b0);
            else
                scan = scan_state_t'(scan + 4'd1);
        end
        if (!used && scan == SCAN_BYTE_SEP)
        begin
            scan = SCAN_BYTE_DIGIT;
            used = (c == CH_DASH);
        end
        if (!used && scan == SCAN_BYTE_DIGIT)
        begin
            nib = hex_value(c);
            if (nib < 0)
                emit_guid(1'b0);
            else
            begin
                byte_bits = {byte_bits[59:0], nib[3:0]};
                digits = digits + 4'd1;
                if (digits >= 2)
                begin
                    digits = 4'd0;
                    bytes_seen = bytes_seen + 4'd1;
                    if (bytes_seen >= 8)
                        emit_guid(1'b1);
                    else
                        scan = SCAN_BYTE_SEP;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            fail_total++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        guid_value_t want;
        if (!rst_n)
        begin
            scan       = SCAN_IDLE;
            digits     = 4'd0;
            bytes_seen = 4'd0;
            group_bits = 64'd0;
            byte_bits  = 64'd0;
            parsed_guids.delete();
            fail_total = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (parsed_guids.size() == 0)
                begin
                    $display("%0t: result with no string pending: expected none, actual ok=%b %h %h %h %h",
                             $time, ok, first_word, second_half, third_half, tail_bytes);
                    fail_total++;
                end
                else
                begin
                    want = parsed_guids.pop_front();
                    check_field("ok", 64'(want.ok), 64'(ok));
                    check_field("first_word", 64'(want.first_word), 64'(first_word));
                    check_field("second_half", 64'(want.second_half), 64'(second_half));
                    check_field("third_half", 64'(want.third_half), 64'(third_half));
                    check_field("tail_bytes", want.tail_bytes, tail_bytes);
                end
            end
            if (in_valid && !in_stall)
                parse_char(char_code, start_req);
        end
        pending_guids <= parsed_guids.size();
        fail_count    <= fail_total;
    end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// GUID text parser testbench
// Sends directed and random GUID strings, well formed and broken, one
// character per transaction with random gaps and stalls on both sides, and
// reports the verdict of the checker.
// ============================================================================

module tb_top
    import gtp_pkg::*;
();

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    localparam logic [CODE_W-1:0] CH_NUL     = 16'h0000;
    localparam logic [CODE_W-1:0] CH_SPACE   = 16'h0020;
    localparam logic [CODE_W-1:0] CH_DASH    = 16'h002D;
    localparam logic [CODE_W-1:0] CH_ZERO    = 16'h0030;
    localparam logic [CODE_W-1:0] CH_UPPER_A = 16'h0041;
    localparam logic [CODE_W-1:0] CH_LOWER_A = 16'h0061;
    localparam logic [CODE_W-1:0] CH_LBRACE  = 16'h007B;
    localparam logic [CODE_W-1:0] CH_RBRACE  = 16'h007D;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [CODE_W-1:0] char_code;
    logic              start_req;
    logic              out_valid;
    logic              out_stall;
    logic              ok;
    logic [31:0]       first_word;
    logic [15:0]       second_half;
    logic [15:0]       third_half;
    logic [63:0]       tail_bytes;
    int                fail_count;
    int                pending_guids;

    logic [CODE_W-1:0] str_buf[$];
    int                items_sent = 0;
    int                quiet_cycles = 0;
    int                hold_left = 0;
    bit                hold_req = 1'b0;
    bit                no_idle = 1'b0;

    guid_text_parser dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .char_code   (char_code),
        .start_req   (start_req),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ok          (ok),
        .first_word  (first_word),
        .second_half (second_half),
        .third_half  (third_half),
        .tail_bytes  (tail_bytes)
    );

    guid_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .char_code     (char_code),
        .start_req     (start_req),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .ok            (ok),
        .first_word    (first_word),
        .second_half   (second_half),
        .third_half    (third_half),
        .tail_bytes    (tail_bytes),
        .fail_count    (fail_count),
        .pending_guids (pending_guids)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            quiet_cycles = 0;
        else
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("guid_text_parser test failed");
                $finish;
            end
        end
    end

    // The receiver owns its hold-off counter; the stimulus only requests it.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !no_idle && ($urandom_range(0, 99) < 26);
    end

    function automatic logic [CODE_W-1:0] blank_char();
        int r;
        r = $urandom_range(9, 14);
        return (r == 14) ? CH_SPACE : CODE_W'(r);
    endfunction

    function automatic logic [CODE_W-1:0] hex_char(input logic [3:0] nib,
                                                   input int letter_case);
        bit upper;
        upper = (letter_case == 1) || (letter_case == 2 && $urandom_range(0, 1) == 1);
        if (nib < 10)
            return CH_ZERO + CODE_W'(nib);
        return (upper ? CH_UPPER_A : CH_LOWER_A) + CODE_W'(nib) - 16'd10;
    endfunction

    // letter_case: 0 lower, 1 upper, 2 mixed at random.
    task automatic build_guid(input logic [127:0] value, input int blanks,
                              input bit brace, input logic [7:0] pair_dash,
                              input int letter_case);
        repeat (blanks) str_buf.push_back(blank_char());
        if (brace)
            str_buf.push_back(CH_LBRACE);
        for (int n = 0; n < 32; n++)
        begin
            if (n == 8 || n == 12 || n == 16)
                str_buf.push_back(CH_DASH);
            if (n >= 16 && n % 2 == 0 && pair_dash[(n - 16) / 2])
                str_buf.push_back(CH_DASH);
            str_buf.push_back(hex_char(value[127 - 4 * n -: 4], letter_case));
        end
    endtask

    task automatic trim_to(input int n);
        while (str_buf.size() > n)
            str_buf.delete(str_buf.size() - 1);
    endtask

    task automatic offer_char(input logic [CODE_W-1:0] code, input logic start);
        while (!no_idle && $urandom_range(0, 99) < 26)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= code;
        start_req <= start;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic send_string();
        for (int i = 0; i < str_buf.size(); i++)
        begin
            offer_char(str_buf[i], i == 0);
            items_sent++;
        end
        str_buf.delete();
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_guids != 0)
            @(posedge clk);
    endtask

    task automatic random_string();
        logic [127:0]      value;
        logic [CODE_W-1:0] bad;
        int                kind;
        int                pos;
        value = {$urandom, $urandom, $urandom, $urandom};
        if ($urandom_range(0, 9) == 0)
            value = '0;
        else if ($urandom_range(0, 9) == 0)
            value = '1;
        build_guid(value, ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0,
                   1'($urandom_range(0, 1)), 8'($urandom), 2);
        kind = $urandom_range(0, 99);
        pos = $urandom_range(0, str_buf.size() - 1);
        if (kind < 70)
        begin
            repeat ($urandom_range(0, 2))
                str_buf.push_back(($urandom_range(0, 1) == 1) ? CH_RBRACE : CODE_W'($urandom));
        end
        else if (kind < 86)
        begin
            case ($urandom_range(0, 8))
                0: bad = CH_NUL;
                1: bad = blank_char();
                2: bad = CH_DASH;
                3: bad = CH_LBRACE;
                4: bad = CH_RBRACE;
                5: bad = CODE_W'($urandom);
                6: bad = CODE_W'($urandom_range(0, 255));
                7:
                begin
                    case ($urandom_range(0, 5))
                        0: bad = 16'h002F;
                        1: bad = 16'h003A;
                        2: bad = 16'h0040;
                        3: bad = 16'h0047;
                        4: bad = 16'h0060;
                        default: bad = 16'h0067;
                    endcase
                end
                default: bad = {8'($urandom_range(1, 255)), 8'h30 + 8'($urandom_range(0, 9))};
            endcase
            str_buf[pos] = bad;
            trim_to(pos + 1 + $urandom_range(0, 2));
        end
        else if (kind < 93)
        begin
            str_buf.insert(pos, CH_DASH);
            trim_to(pos + 1 + $urandom_range(0, 2));
        end
        else
            trim_to(pos + 1);
        send_string();
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 3)) offer_char(CODE_W'($urandom), 1'b0);
    endtask

    initial
    begin
        int strings_done;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        char_code = '0;
        start_req = 1'b0;
        out_stall = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        offer_char(CH_ZERO, 1'b0);
        offer_char(CH_LBRACE, 1'b0);
        offer_char(16'hFFFF, 1'b0);

        build_guid('0, 0, 1'b0, 8'h00, 0);
        send_string();

        build_guid('1, 0, 1'b1, 8'hFF, 0);
        str_buf.push_back(CH_RBRACE);
        send_string();
        offer_char(CH_ZERO, 1'b0);

        for (int b = 9; b <= 13; b++)
            str_buf.push_back(CODE_W'(b));
        str_buf.push_back(CH_SPACE);
        build_guid(128'h0123456789ABCDEF_FEDCBA9876543210, 0, 1'b0, 8'h00, 1);
        send_string();

        str_buf.push_back(CH_NUL);
        send_string();

        str_buf.push_back(CH_SPACE);
        str_buf.push_back(CH_NUL);
        send_string();

        build_guid(128'h89ABCDEF_01234567_00FF00FF_A5A55A5A, 0, 1'b0, 8'h00, 2);
        str_buf[5] = CH_NUL;
        trim_to(6);
        send_string();

        str_buf.push_back(CH_LBRACE);
        str_buf.push_back(CH_SPACE);
        str_buf.push_back(CH_ZERO);
        send_string();

        build_guid(128'h1, 0, 1'b0, 8'h00, 2);
        str_buf[3] = CH_SPACE;
        trim_to(4);
        send_string();

        build_guid(128'h12345678_9ABC_DEF0_123456789ABCDEF0, 0, 1'b0, 8'h01, 2);
        str_buf.insert(19, CH_DASH);
        send_string();

        build_guid('1, 0, 1'b0, 8'h00, 1);
        str_buf[0] = 16'h0130;
        trim_to(1);
        send_string();

        str_buf.push_back(16'h0120);
        send_string();

        build_guid(128'h5, 0, 1'b0, 8'h00, 0);
        str_buf[8] = CH_ZERO;
        send_string();

        build_guid(128'hDEADBEEF, 0, 1'b1, 8'hAA, 2);
        trim_to(20);
        send_string();

        str_buf.push_back(CH_LBRACE);
        str_buf.push_back(CH_LBRACE);
        send_string();
        offer_char(CH_DASH, 1'b0);

        build_guid(128'h0, 0, 1'b0, 8'h00, 0);
        str_buf[1] = 16'h0067;
        trim_to(2);
        send_string();

        build_guid(128'hCAFEF00D_1234_5678_9ABCDEF012345678, 2, 1'b1, 8'h5A, 2);
        send_string();

        drain();

        strings_done = 0;
        while (items_sent < 1300 || strings_done < 26)
        begin
            if (strings_done == 8 || strings_done == 24)
                hold_req = 1'b1;
            if (strings_done == 14)
                drain();
            no_idle = (strings_done >= 16 && strings_done < 22);
            random_string();
            strings_done++;
        end
        no_idle = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("guid_text_parser test passed");
        else
            $display("guid_text_parser test failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/gtp_pkg.sv
design/gtp_char_stage.sv
design/gtp_parser.sv
design/gtp_result_stage.sv
design/guid_text_parser.sv
sim/guid_checker.sv
sim/tb_top.sv
